// ----- sv/bfm2_pkg.sv -----
// ----------------------------------------------------------------------------
// bfm2_pkg
// shared types, codes and hash constants for the murmur2 bloom filter
// ----------------------------------------------------------------------------
`default_nettype none
package bfm2_pkg;

    localparam int unsigned MAX_BITS_DEF      = 65536;
    localparam int unsigned MAX_HASHES_DEF    = 8;
    localparam int unsigned MAX_KEY_BYTES_DEF = 16;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int unsigned MIX_SHIFT   = 24;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_FIND  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_MAYBE   = 3'd1;
    localparam logic [2:0] ST_ABSENT  = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BAD_ARG = 3'd4;
    localparam logic [2:0] ST_CLEARED = 3'd5;

    localparam logic [2:0] REG_NUM_HASHES = 3'd0;
    localparam logic [2:0] REG_BIT_COUNT  = 3'd1;
    localparam logic [2:0] REG_CAPACITY   = 3'd2;
    localparam logic [2:0] REG_SEEDS_0_1  = 3'd3;
    localparam logic [2:0] REG_SEEDS_2_3  = 3'd4;
    localparam logic [2:0] REG_SEEDS_4_5  = 3'd5;
    localparam logic [2:0] REG_SEEDS_6_7  = 3'd6;

    typedef enum logic [1:0] {
        OP_HASH,
        OP_IMMEDIATE,
        OP_CLEAR
    } op_kind_t;

    // one classified transaction travelling from front to back
    typedef struct packed {
        op_kind_t    kind;
        logic        is_add;
        logic [2:0]  status;
        logic [127:0] key;
        logic [4:0]  len;
        logic [3:0]  nh;
    } job_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_HINIT,
        BK_KMUL1,
        BK_KMUL2,
        BK_HMUL,
        BK_TAIL,
        BK_TMUL,
        BK_FMUL,
        BK_FIN,
        BK_MOD,
        BK_READ,
        BK_TEST,
        BK_CLEAR,
        BK_DONE
    } back_state_t;

endpackage
`default_nettype wire

// ----- sv/bfm2_front.sv -----
// ----------------------------------------------------------------------------
// bfm2_front
// accepts commands, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none
module bfm2_front #(
    parameter int unsigned MAX_HASHES    = bfm2_pkg::MAX_HASHES_DEF,
    parameter int unsigned MAX_KEY_BYTES = bfm2_pkg::MAX_KEY_BYTES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [1:0]       command,
    input  wire logic [63:0]      key_low,
    input  wire logic [63:0]      key_high,
    input  wire logic [4:0]       key_length,
    input  wire logic [3:0]       num_hashes,
    input  wire logic             pop,
    output logic                  job_valid,
    output bfm2_pkg::job_t        job
);
    import bfm2_pkg::*;

    localparam int unsigned DEPTH = 2;

    job_t        q_reg [DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    job_t        incoming;
    logic        push;
    logic [4:0]  len_sat;
    logic [3:0]  nh_sat;
    logic [127:0] key_full;
    logic [127:0] key_masked;

    always_comb
    begin
        len_sat  = (key_length > 5'(MAX_KEY_BYTES)) ? 5'(MAX_KEY_BYTES) : key_length;
        nh_sat   = (num_hashes > 4'(MAX_HASHES)) ? 4'(MAX_HASHES) : num_hashes;
        key_full = {key_high, key_low};
        for (int i = 0; i < 16; i++)
        begin
            key_masked[i*8 +: 8] = (5'(i) < len_sat) ? key_full[i*8 +: 8] : 8'd0;
        end
        incoming        = '0;
        incoming.key    = key_masked;
        incoming.len    = len_sat;
        incoming.nh     = nh_sat;
        incoming.is_add = (command == CMD_ADD);
        unique case (command)
            CMD_ADD:
            begin
                incoming.kind = OP_HASH;
            end
            CMD_FIND:
            begin
                if (len_sat == 5'd0)
                begin
                    incoming.kind   = OP_IMMEDIATE;
                    incoming.status = ST_BAD_ARG;
                end
                else
                begin
                    incoming.kind = OP_HASH;
                end
            end
            CMD_CLEAR:
            begin
                incoming.kind = OP_CLEAR;
            end
            default:
            begin
                incoming.kind   = OP_IMMEDIATE;
                incoming.status = ST_BAD_ARG;
            end
        endcase
    end

    // one transaction in flight at a time keeps results in order with state
    assign busy      = (cnt_reg != 2'd0);
    assign push      = start && !busy;
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (pop && job_valid);
        cnt_next    = cnt_reg + 2'(push) - 2'(pop && job_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= incoming;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(DEPTH)) else $error("queue overflow");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !(pop && job_valid)) else $error("pop from empty queue");
    a_busy_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> busy) else $error("busy not raised after accept");

endmodule
`default_nettype wire

// ----- sv/bfm2_back.sv -----
// ----------------------------------------------------------------------------
// bfm2_back
// hash sequencer, modulo unit and filter bit memory
// ----------------------------------------------------------------------------
`default_nettype none
module bfm2_back #(
    parameter int unsigned MAX_BITS   = bfm2_pkg::MAX_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             job_valid,
    input  wire bfm2_pkg::job_t   job,
    output logic                  pop,
    input  wire logic [16:0]      bit_count,
    input  wire logic [15:0]      capacity,
    input  wire logic [255:0]     seeds,
    output logic                  done,
    output logic [2:0]            status,
    output logic [15:0]           stored_count
);
    import bfm2_pkg::*;

    localparam int unsigned AW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
    localparam int unsigned CW = $clog2(MAX_BITS + 1);

    back_state_t state_reg, state_next;
    logic        mem [MAX_BITS];
    logic        rd_bit_reg;

    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;
    logic [2:0]  word_reg, word_next;
    logic [3:0]  hidx_reg, hidx_next;
    logic [5:0]  mstep_reg, mstep_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [2:0]  st_reg, st_next;
    logic [15:0] count_reg, count_next;
    logic        done_reg, done_next;
    logic [2:0]  status_reg, status_next;

    logic        mem_we;
    logic        mem_wd;
    logic [AW-1:0] mem_wa;
    logic [CW-1:0] bc_eff;
    logic [CW:0]   trial;
    logic [31:0] seed_sel;
    logic [31:0] cur_word;
    logic [1:0]  rest;
    logic [2:0]  full_words;
    logic [7:0]  tb0, tb1, tb2;
    logic [6:0]  tail_base;

    always_comb
    begin
        if (bit_count == 17'd0)
        begin
            bc_eff = CW'(1);
        end
        else if (32'(bit_count) > 32'(MAX_BITS))
        begin
            bc_eff = CW'(MAX_BITS);
        end
        else
        begin
            bc_eff = CW'(bit_count);
        end
        seed_sel   = seeds[32*hidx_reg[2:0] +: 32];
        cur_word   = job.key[32*word_reg[1:0] +: 32];
        full_words = 3'(job.len >> 2);
        rest       = job.len[1:0];
        tail_base  = 7'({full_words, 5'd0});
        tb0        = job.key[tail_base +: 8];
        tb1        = job.key[tail_base + 7'd8 +: 8];
        tb2        = job.key[tail_base + 7'd16 +: 8];
        trial      = {rem_reg, h_reg[31 - mstep_reg[4:0]]} - {1'b0, bc_eff};
    end

    always_comb
    begin
        state_next  = state_reg;
        h_next      = h_reg;
        k_next      = k_reg;
        word_next   = word_reg;
        hidx_next   = hidx_reg;
        mstep_next  = mstep_reg;
        rem_next    = rem_reg;
        addr_next   = addr_reg;
        st_next     = st_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        pop         = 1'b0;
        mem_we      = 1'b0;
        mem_wd      = 1'b0;
        mem_wa      = addr_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    hidx_next = 4'd0;
                    addr_next = '0;
                    priority if (job.kind == OP_IMMEDIATE)
                    begin
                        st_next    = job.status;
                        state_next = BK_DONE;
                    end
                    else if (job.kind == OP_CLEAR)
                    begin
                        st_next    = ST_CLEARED;
                        state_next = BK_CLEAR;
                    end
                    else if (job.is_add && count_reg >= capacity)
                    begin
                        st_next    = ST_FULL;
                        state_next = BK_DONE;
                    end
                    else
                    begin
                        st_next    = job.is_add ? ST_ADDED : ST_MAYBE;
                        state_next = (job.nh == 4'd0) ? BK_DONE : BK_HINIT;
                    end
                end
            end
            BK_HINIT:
            begin
                h_next     = seed_sel ^ 32'(job.len);
                word_next  = 3'd0;
                state_next = (full_words == 3'd0) ? BK_TAIL : BK_KMUL1;
            end
            BK_KMUL1:
            begin
                k_next     = cur_word * MIX_MUL;
                state_next = BK_KMUL2;
            end
            BK_KMUL2:
            begin
                k_next     = (k_reg ^ (k_reg >> MIX_SHIFT)) * MIX_MUL;
                state_next = BK_HMUL;
            end
            BK_HMUL:
            begin
                h_next     = (h_reg * MIX_MUL) ^ k_reg;
                word_next  = word_reg + 3'd1;
                state_next = (word_reg + 3'd1 == full_words) ? BK_TAIL : BK_KMUL1;
            end
            BK_TAIL:
            begin
                if (rest == 2'd0)
                begin
                    state_next = BK_FMUL;
                end
                else
                begin
                    h_next = h_reg ^ ((rest == 2'd3) ? {8'd0, tb2, 16'd0} : 32'd0)
                                   ^ ((rest >= 2'd2) ? {16'd0, tb1, 8'd0} : 32'd0)
                                   ^ {24'd0, tb0};
                    state_next = BK_TMUL;
                end
            end
            BK_TMUL:
            begin
                h_next     = h_reg * MIX_MUL;
                state_next = BK_FMUL;
            end
            BK_FMUL:
            begin
                h_next     = (h_reg ^ (h_reg >> FIN_SHIFT_A)) * MIX_MUL;
                state_next = BK_FIN;
            end
            BK_FIN:
            begin
                h_next     = h_reg ^ (h_reg >> FIN_SHIFT_B);
                rem_next   = '0;
                mstep_next = 6'd0;
                state_next = BK_MOD;
            end
            BK_MOD:
            begin
                // restoring remainder, one hash bit a cycle
                rem_next = trial[CW] ? CW'({rem_reg, h_reg[31 - mstep_reg[4:0]]})
                                     : CW'(trial);
                mstep_next = mstep_reg + 6'd1;
                if (mstep_reg == 6'd31)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                addr_next  = AW'(rem_reg);
                state_next = BK_TEST;
            end
            BK_TEST:
            begin
                // read data for addr_reg arrives here
                if (job.is_add)
                begin
                    mem_we = 1'b1;
                    mem_wd = 1'b1;
                end
                else if (!rd_bit_reg)
                begin
                    st_next = ST_ABSENT;
                end
                hidx_next = hidx_reg + 4'd1;
                if ((hidx_reg + 4'd1 == job.nh) || (!job.is_add && !rd_bit_reg))
                begin
                    state_next = BK_DONE;
                end
                else
                begin
                    state_next = BK_HINIT;
                end
            end
            BK_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wd    = 1'b0;
                addr_next = addr_reg + AW'(1);
                if (32'(addr_reg) == 32'(MAX_BITS - 1))
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                // the sweep after reset finishes here with no transaction queued
                pop         = 1'b1;
                done_next   = job_valid;
                status_next = st_reg;
                if (job_valid && job.kind == OP_HASH && job.is_add && st_reg == ST_ADDED)
                begin
                    count_next = count_reg + 16'd1;
                end
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CLEAR;
            addr_reg  <= '0;
            count_reg <= 16'd0;
            done_reg  <= 1'b0;
            hidx_reg  <= 4'd0;
            st_reg    <= ST_CLEARED;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            hidx_reg  <= hidx_next;
            st_reg    <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg      <= h_next;
        k_reg      <= k_next;
        word_reg   <= word_next;
        mstep_reg  <= mstep_next;
        rem_reg    <= rem_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_bit_reg <= mem[addr_next];
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign stored_count = count_reg;

    a_pop_one: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == BK_DONE)) else $error("pop outside done");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("result strobe longer than a cycle");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(state_reg == BK_DONE))
        else $error("count changed outside completion");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_READ) |-> (rem_reg < bc_eff)) else $error("remainder out of range");

endmodule
`default_nettype wire

// ----- sv/bfm2_regs.sv -----
// ----------------------------------------------------------------------------
// bfm2_regs
// apb configuration registers
// ----------------------------------------------------------------------------
`default_nettype none
module bfm2_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output logic [3:0]        num_hashes,
    output logic [16:0]       bit_count,
    output logic [15:0]       capacity,
    output logic [255:0]      seeds
);
    import bfm2_pkg::*;

    logic [3:0]   nh_reg;
    logic [16:0]  bc_reg;
    logic [15:0]  cap_reg;
    logic [255:0] seeds_reg;
    logic         wr;
    logic [2:0]   idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nh_reg    <= 4'd1;
            bc_reg    <= 17'd65536;
            cap_reg   <= 16'hffff;
            seeds_reg <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_NUM_HASHES: nh_reg <= pwdata[3:0];
                REG_BIT_COUNT:  bc_reg <= pwdata[16:0];
                REG_CAPACITY:   cap_reg <= pwdata[15:0];
                REG_SEEDS_0_1:  seeds_reg[63:0]    <= pwdata;
                REG_SEEDS_2_3:  seeds_reg[127:64]  <= pwdata;
                REG_SEEDS_4_5:  seeds_reg[191:128] <= pwdata;
                REG_SEEDS_6_7:  seeds_reg[255:192] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_NUM_HASHES: prdata = 64'(nh_reg);
            REG_BIT_COUNT:  prdata = 64'(bc_reg);
            REG_CAPACITY:   prdata = 64'(cap_reg);
            REG_SEEDS_0_1:  prdata = seeds_reg[63:0];
            REG_SEEDS_2_3:  prdata = seeds_reg[127:64];
            REG_SEEDS_4_5:  prdata = seeds_reg[191:128];
            REG_SEEDS_6_7:  prdata = seeds_reg[255:192];
            default:        prdata = 64'd0;
        endcase
    end

    assign num_hashes = nh_reg;
    assign bit_count  = bc_reg;
    assign capacity   = cap_reg;
    assign seeds      = seeds_reg;

endmodule
`default_nettype wire

// ----- sv/bloom_filter_murmur2.sv -----
// ----------------------------------------------------------------------------
// bloom_filter_murmur2
// bloom filter over an on-chip bit memory, hashed with 32-bit murmur2
// ----------------------------------------------------------------------------
// One transaction is in flight at a time; busy is high from the accept until
// the result strobe. An add or find runs the hash and the bit-serial modulo
// unit once per hash function; a find stops after the first clear bit. A
// full or bad-argument transaction skips the hash, and a clear sweeps the
// whole bit memory. After reset the bit memory is swept clear with busy
// high. Results come as a one-cycle done strobe and cannot be stalled.
`default_nettype none
module bloom_filter_murmur2 #(
    parameter int unsigned MAX_BITS      = bfm2_pkg::MAX_BITS_DEF,
    parameter int unsigned MAX_HASHES    = bfm2_pkg::MAX_HASHES_DEF,
    parameter int unsigned MAX_KEY_BYTES = bfm2_pkg::MAX_KEY_BYTES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [1:0]   command,
    input  wire logic [63:0]  key_low,
    input  wire logic [63:0]  key_high,
    input  wire logic [4:0]   key_length,
    output logic              done,
    output logic [2:0]        status,
    output logic [15:0]       stored_count,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    import bfm2_pkg::*;

    logic [3:0]   num_hashes;
    logic [16:0]  bit_count;
    logic [15:0]  capacity;
    logic [255:0] seeds;
    logic         job_valid;
    logic         pop;
    logic         front_busy;
    logic         back_busy;
    job_t         job;

    bfm2_regs u_regs (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .num_hashes, .bit_count, .capacity, .seeds
    );

    bfm2_front #(.MAX_HASHES(MAX_HASHES), .MAX_KEY_BYTES(MAX_KEY_BYTES)) u_front (
        .clk, .rst_n, .start(start && !back_busy), .busy(front_busy),
        .command, .key_low, .key_high, .key_length, .num_hashes,
        .pop, .job_valid, .job
    );

    bfm2_back #(.MAX_BITS(MAX_BITS)) u_back (
        .clk, .rst_n, .job_valid, .job, .pop, .bit_count, .capacity, .seeds,
        .done, .status, .stored_count
    );

    // back end busy covers the clearing sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            back_busy <= 1'b1;
        end
        else if (pop)
        begin
            back_busy <= 1'b0;
        end
    end

    assign busy = front_busy || back_busy;

endmodule
`default_nettype wire
